// File: rtl/core/tap_pkg.sv
package tap_pkg;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_pixel;

    typedef struct packed {
        logic [11:0] tile_column;
        logic [11:0] tile_row;
        logic [7:0]  mean_red;
        logic [7:0]  mean_green;
        logic [7:0]  mean_blue;
        logic        frame_done;
    } t_tile;

    // classified pixel handed from front to back
    typedef struct packed {
        t_pixel      pix;
        logic [11:0] col_idx;
        logic [11:0] tile_row;
        logic        first;
        logic        emit;
        logic        frame_done;
        logic [12:0] count;
    } t_job;

    localparam int SumW = 20;
    localparam logic [1:0] RegWidth  = 2'd0;
    localparam logic [1:0] RegHeight = 2'd1;
    localparam logic [1:0] RegTile   = 2'd2;

endpackage

// File: rtl/core/tap_front.sv
module tap_front
    import tap_pkg::*;
#(
    parameter int MAX_TILE = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_restart,
    input  logic [12:0] i_width,
    input  logic [12:0] i_height,
    input  logic [6:0]  i_tile,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_pixel      i_pix,
    output logic        o_valid,
    input  logic        i_stall,
    output t_job        o_job
);
    logic [12:0] w, h;
    logic [6:0]  ts;
    logic [11:0] r_pcol, r_prow, r_tcol, r_trow;
    logic [6:0]  r_cit, r_rit;
    logic        line_end, last_row, cx_end, ry_end, take;

    always_comb begin
        w  = (i_width == 13'd0) ? 13'd1 : ((i_width > 13'd4096) ? 13'd4096 : i_width);
        h  = (i_height == 13'd0) ? 13'd1 : ((i_height > 13'd4096) ? 13'd4096 : i_height);
        ts = (i_tile == 7'd0) ? 7'd1
           : ((int'(i_tile) > MAX_TILE) ? 7'(MAX_TILE) : i_tile);
        line_end = ({1'b0, r_pcol} + 13'd1) >= w;
        last_row = ({1'b0, r_prow} + 13'd1) >= h;
        cx_end   = (r_cit + 7'd1) >= ts;
        ry_end   = (r_rit + 7'd1) >= ts;
    end

    assign o_stall = o_valid && i_stall;
    assign take = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (take) begin
            o_valid <= 1'b1;
        end else if (!i_stall) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_pcol <= '0; r_prow <= '0; r_cit <= '0; r_rit <= '0;
            r_tcol <= '0; r_trow <= '0;
        end else begin
            if (take) begin
                o_job.pix        <= i_pix;
                o_job.col_idx    <= r_tcol;
                o_job.tile_row   <= r_trow;
                o_job.first      <= (r_cit == 7'd0) && (r_rit == 7'd0);
                o_job.emit       <= (line_end || cx_end) && (last_row || ry_end);
                o_job.frame_done <= line_end && last_row;
                o_job.count      <= ({6'd0, r_cit} + 13'd1) * ({6'd0, r_rit} + 13'd1);
                if (line_end) begin
                    r_pcol <= '0; r_cit <= '0; r_tcol <= '0;
                    if (last_row) begin
                        r_prow <= '0; r_rit <= '0; r_trow <= '0;
                    end else begin
                        r_prow <= r_prow + 12'd1;
                        if (ry_end) begin
                            r_rit <= '0; r_trow <= r_trow + 12'd1;
                        end else begin
                            r_rit <= r_rit + 7'd1;
                        end
                    end
                end else begin
                    r_pcol <= r_pcol + 12'd1;
                    if (cx_end) begin
                        r_cit <= '0; r_tcol <= r_tcol + 12'd1;
                    end else begin
                        r_cit <= r_cit + 7'd1;
                    end
                end
            end
        end
    end
endmodule

// File: rtl/core/tap_queue.sv
module tap_queue
    import tap_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_job i_job,
    output logic o_valid,
    input  logic i_stall,
    output t_job o_job
);
    t_job       r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       push, pop;

    assign o_stall = r_cnt == 3'd4;
    assign o_valid = r_cnt != 3'd0;
    assign o_job   = r_mem[r_rp];
    assign push    = i_valid && !o_stall;
    assign pop     = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_job;
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 2'd1;
            if (pop)  r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + 3'(push) - 3'(pop);
        end
    end

    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= 3'd4)
        else $error("queue count overflow");
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> !(r_cnt == 3'd0))
        else $error("full queue emptied at once");
    a_noover: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 3'd4 && !pop) |=> r_cnt == 3'd4)
        else $error("full queue lost entry");
endmodule

// File: rtl/core/tap_back.sv
module tap_back
    import tap_pkg::*;
#(
    parameter int MAX_WIDTH = 4096
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_job i_job,
    output logic o_valid,
    input  logic i_stall,
    output t_tile o_tile
);
    localparam int AW = $clog2(MAX_WIDTH);
    typedef enum logic [1:0] {S_IDLE, S_READ, S_DIV, S_OUT} t_state;

    t_state            r_state;
    logic [SumW-1:0]   r_rs [MAX_WIDTH];
    logic [SumW-1:0]   r_gs [MAX_WIDTH];
    logic [SumW-1:0]   r_bs [MAX_WIDTH];
    logic [SumW-1:0]   r_rd_r, r_rd_g, r_rd_b;
    t_job              r_job;
    logic              r_inr;
    logic [SumW-1:0]   r_nr, r_ng, r_nb;   // remainders / dividends
    logic [7:0]        r_qr, r_qg, r_qb;
    logic [SumW-1:0]   sr, sg, sb;
    logic [4:0]        r_bit;
    logic [SumW+7:0]   dsh;

    assign o_stall = r_state != S_IDLE;
    assign o_valid = r_state == S_OUT;
    assign dsh     = {15'd0, r_job.count} << r_bit;

    // a column beyond the sum store contributes nothing
    always_comb begin
        sr = !r_inr ? '0 : (r_job.first ? SumW'(r_job.pix.red_in)
           : r_rd_r + SumW'(r_job.pix.red_in));
        sg = !r_inr ? '0 : (r_job.first ? SumW'(r_job.pix.green_in)
           : r_rd_g + SumW'(r_job.pix.green_in));
        sb = !r_inr ? '0 : (r_job.first ? SumW'(r_job.pix.blue_in)
           : r_rd_b + SumW'(r_job.pix.blue_in));
    end

    // sum store; divider: restoring, one quotient bit per cycle, only low 8 bits kept
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_rd_r <= r_rs[AW'(i_job.col_idx)];
            r_rd_g <= r_gs[AW'(i_job.col_idx)];
            r_rd_b <= r_bs[AW'(i_job.col_idx)];
        end
        if (r_state == S_READ && r_inr) begin
            r_rs[AW'(r_job.col_idx)] <= sr;
            r_gs[AW'(r_job.col_idx)] <= sg;
            r_bs[AW'(r_job.col_idx)] <= sb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_valid) begin
                    r_job   <= i_job;
                    r_inr   <= 32'(i_job.col_idx) < MAX_WIDTH;
                    r_state <= S_READ;
                end
                S_READ: begin
                    r_nr <= sr; r_ng <= sg; r_nb <= sb;
                    r_bit <= 5'd7;
                    r_state <= r_job.emit ? S_DIV : S_IDLE;
                end
                S_DIV: begin
                    // a mean fits 8 bits since each sum is at most 255 times the count
                    r_qr[r_bit[2:0]] <= {8'd0, r_nr} >= dsh;
                    r_qg[r_bit[2:0]] <= {8'd0, r_ng} >= dsh;
                    r_qb[r_bit[2:0]] <= {8'd0, r_nb} >= dsh;
                    if ({8'd0, r_nr} >= dsh) r_nr <= r_nr - dsh[SumW-1:0];
                    if ({8'd0, r_ng} >= dsh) r_ng <= r_ng - dsh[SumW-1:0];
                    if ({8'd0, r_nb} >= dsh) r_nb <= r_nb - dsh[SumW-1:0];
                    if (r_bit == 5'd0) r_state <= S_OUT;
                    else r_bit <= r_bit - 5'd1;
                end
                S_OUT: if (!i_stall) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_tile.tile_column = r_job.col_idx;
        o_tile.tile_row    = r_job.tile_row;
        o_tile.mean_red    = r_qr;
        o_tile.mean_green  = r_qg;
        o_tile.mean_blue   = r_qb;
        o_tile.frame_done  = r_job.frame_done;
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && i_stall) |=> r_state == S_OUT)
        else $error("result dropped under stall");
    a_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> r_bit <= 5'd7)
        else $error("divider step out of range");
    a_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ && !r_job.emit) |=> r_state == S_IDLE)
        else $error("non-emitting pixel entered divider");
endmodule

// File: rtl/core/tile_average_pixelate_top.sv
// path from an accepted tile-completing pixel to its result when the queue is
//   empty: front register, queue, sum read-modify-write, 8-step shared divider
// back end: accepts a pixel only when idle, i.e. once the last one's sum update and any
//   division and output end; input stalls once the 4-entry queue and front reg fill
// reset: synchronous active low; counters and queue clear, sums undefined until written
module tile_average_pixelate_top
    import tap_pkg::*;
#(
    parameter int MAX_WIDTH = 4096,
    parameter int MAX_TILE  = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_pixel      i_pixel,
    output logic        o_valid,
    input  logic        i_stall,
    output t_tile       o_tile
);
    logic [12:0] r_width, r_height;
    logic [6:0]  r_tile;
    logic        wr, restart, f_v, f_s, q_v, q_s;
    t_job        f_j, q_j;

    assign pready  = 1'b1;
    assign wr      = psel && penable && pwrite;
    assign restart = wr && (paddr[3:2] inside {RegWidth, RegHeight, RegTile});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= 13'd640; r_height <= 13'd480; r_tile <= 7'd8;
        end else if (wr) begin
            unique case (paddr[3:2])
                RegWidth:  r_width  <= pwdata[12:0];
                RegHeight: r_height <= pwdata[12:0];
                RegTile:   r_tile   <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            RegWidth:  prdata = {19'd0, r_width};
            RegHeight: prdata = {19'd0, r_height};
            RegTile:   prdata = {25'd0, r_tile};
            default:   prdata = '0;
        endcase
    end

    tap_front #(.MAX_TILE(MAX_TILE)) u_front (
        .i_clk, .i_rst_n, .i_restart(restart), .i_width(r_width), .i_height(r_height),
        .i_tile(r_tile), .i_valid, .o_stall, .i_pix(i_pixel),
        .o_valid(f_v), .i_stall(f_s), .o_job(f_j)
    );
    tap_queue u_queue (
        .i_clk, .i_rst_n, .i_valid(f_v), .o_stall(f_s), .i_job(f_j),
        .o_valid(q_v), .i_stall(q_s), .o_job(q_j)
    );
    tap_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
        .i_clk, .i_rst_n, .i_valid(q_v), .o_stall(q_s), .i_job(q_j),
        .o_valid, .i_stall, .o_tile
    );
endmodule

// File: test/tb_top.sv
module tb_top;
    import tap_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    class tile_scoreboard;
        int unsigned width_cfg, height_cfg, tile_cfg;
        bit [19:0] red_acc[4096], green_acc[4096], blue_acc[4096];
        int unsigned px_col, px_row, col_in, row_in, tcol;
        t_tile pending_tiles[$];
        int errors;
        int tiles_seen;

        function new();
            width_cfg = 640; height_cfg = 480; tile_cfg = 8;
            errors = 0; tiles_seen = 0;
            restart();
        endfunction

        function void restart();
            px_col = 0; px_row = 0; col_in = 0; row_in = 0; tcol = 0;
        endfunction

        function int unsigned clip(int unsigned v, int unsigned hi);
            if (v == 0) return 1;
            return (v > hi) ? hi : v;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                RegWidth:  width_cfg = val[12:0];
                RegHeight: height_cfg = val[12:0];
                RegTile:   tile_cfg = val[6:0];
                default:   return;
            endcase
            restart();
        endfunction

        function void note_pixel(t_pixel p);
            int unsigned w, h, ts, cnt;
            bit first, line_end, x_end, y_end, frame_end;
            bit [19:0] sr, sg, sb;
            t_tile t;
            w = clip(width_cfg, 4096);
            h = clip(height_cfg, 4096);
            ts = clip(tile_cfg, 64);
            first = (col_in == 0) && (row_in == 0);
            sr = 0; sg = 0; sb = 0;
            if (tcol < 4096) begin
                if (first) begin
                    sr = p.red_in; sg = p.green_in; sb = p.blue_in;
                end else begin
                    sr = red_acc[tcol] + p.red_in;
                    sg = green_acc[tcol] + p.green_in;
                    sb = blue_acc[tcol] + p.blue_in;
                end
                red_acc[tcol] = sr; green_acc[tcol] = sg; blue_acc[tcol] = sb;
            end
            line_end = px_col + 1 >= w;
            x_end = line_end || (col_in + 1 >= ts);
            y_end = (px_row + 1 >= h) || (row_in + 1 >= ts);
            frame_end = line_end && (px_row + 1 >= h);
            if (x_end && y_end) begin
                cnt = (col_in + 1) * (row_in + 1);
                t.tile_column = tcol[11:0];
                t.tile_row = 12'((px_row / ts));
                t.mean_red = 8'(sr / cnt);
                t.mean_green = 8'(sg / cnt);
                t.mean_blue = 8'(sb / cnt);
                t.frame_done = frame_end;
                pending_tiles.push_back(t);
            end
            if (line_end) begin
                px_col = 0; col_in = 0; tcol = 0;
                if (frame_end) begin
                    px_row = 0; row_in = 0;
                end else begin
                    px_row++;
                    row_in = (row_in + 1 >= ts) ? 0 : row_in + 1;
                end
            end else begin
                px_col++;
                if (col_in + 1 >= ts) begin
                    col_in = 0; tcol++;
                end else begin
                    col_in++;
                end
            end
        endfunction

        task report(string what, int got, int want);
            $display("tile error %s: got %0d expected %0d at %0t", what, got, want, $realtime);
            errors++;
        endtask

        task check_tile(t_tile got);
            t_tile want;
            tiles_seen++;
            if (pending_tiles.size() == 0) begin
                report("unexpected tile, column", got.tile_column, -1);
                return;
            end
            want = pending_tiles.pop_front();
            if (got.tile_column != want.tile_column)
                report("tile_column", got.tile_column, want.tile_column);
            if (got.tile_row != want.tile_row) report("tile_row", got.tile_row, want.tile_row);
            if (got.mean_red != want.mean_red) report("mean_red", got.mean_red, want.mean_red);
            if (got.mean_green != want.mean_green)
                report("mean_green", got.mean_green, want.mean_green);
            if (got.mean_blue != want.mean_blue)
                report("mean_blue", got.mean_blue, want.mean_blue);
            if (got.frame_done != want.frame_done)
                report("frame_done", got.frame_done, want.frame_done);
        endtask
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [3:0]  paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid = 0;
    logic        o_stall;
    t_pixel      i_pixel = '0;
    logic        o_valid;
    logic        i_stall = 0;
    t_tile       o_tile;

    tile_scoreboard sb = new();
    bit quiet_tail = 0;
    int idle_cycles = 0;
    int pixels_sent = 0;
    int settings_run = 0;

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    tile_average_pixelate_top u_dut (.*);

    // result side: check at rising edge, random stall bursts
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_tile(o_tile);
        if (i_rst_n && ((i_valid && !o_stall) || (o_valid && !i_stall))) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int burst;
        forever begin
            @(negedge i_clk);
            if (!quiet_tail && burst == 0 && $urandom_range(0, 5) == 0)
                burst = $urandom_range(1, 3);
            if (burst > 0) begin
                i_stall <= 1;
                burst--;
            end else begin
                i_stall <= 0;
            end
        end
    end

    task write_reg(logic [1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.set_reg(idx, val);
        @(negedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    task send_pixel(t_pixel p);
        if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            i_valid <= 0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        i_valid <= 1;
        i_pixel <= p;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_pixel(p);
        pixels_sent++;
        @(negedge i_clk);
    endtask

    // called at a falling edge right after the last accepted pixel
    task drain();
        i_valid <= 0;
        while (sb.pending_tiles.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    function t_pixel rand_pixel();
        t_pixel p;
        p = t_pixel'(24'($urandom));
        return p;
    endfunction

    // one frame keeps sum reads on written entries; long frames stop early and the
    // next register write restarts the frame
    task run_frame(int unsigned w, int unsigned h, int unsigned ts, int mode);
        int n;
        t_pixel p;
        write_reg(RegWidth, w);
        write_reg(RegHeight, h);
        write_reg(RegTile, ts);
        settings_run++;
        n = sb.clip(w, 4096) * sb.clip(h, 4096);
        if (n > 400) n = 400;
        for (int k = 0; k < n; k++) begin
            case (mode)
                0: p = '1;
                1: p = '0;
                default: p = rand_pixel();
            endcase
            send_pixel(p);
        end
        drain();
    endtask

    initial begin
        int unsigned w, h, ts;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        // directed: extremes of pixel values, tile sizes and clamped dimensions
        run_frame(1, 1, 1, 0);
        run_frame(3, 2, 0, 1);
        run_frame(5, 3, 64, 0);
        run_frame(0, 0, 127, 2);
        run_frame(8191, 1, 64, 0);
        run_frame(1, 8191, 2, 2);
        run_frame(4096, 1, 64, 2);
        run_frame(9, 4, 2, 0);
        while (pixels_sent < 2000) begin
            if (pixels_sent > 1700) quiet_tail = 1;
            w = $urandom_range(1, 24);
            h = $urandom_range(1, 12);
            ts = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 6);
            run_frame(w, h, ts, 2);
        end
        $display("covered %0d pixels over %0d frame settings, %0d tiles checked",
                 pixels_sent, settings_run, sb.tiles_seen);
        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
